[src/srlc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlc_pkg: shared types and constants of the selective-repeat link controller
// Event and action codes, beat structures and the circular window compare.
// ----------------------------------------------------------------------------
package srlc_pkg;

   // sequence space and window
   localparam int SEQ_W  = 4;
   localparam int SLOT_W = 3;
   localparam int WINDOW = 8;
   localparam int CNT_W  = 4;

   // event codes
   localparam logic [2:0] FUNC_NET_READY = 3'd0;
   localparam logic [2:0] FUNC_PHY_READY = 3'd1;
   localparam logic [2:0] FUNC_FRAME_RX  = 3'd2;
   localparam logic [2:0] FUNC_DATA_TMO  = 3'd3;
   localparam logic [2:0] FUNC_ACK_TMO   = 3'd4;

   // received frame kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_ACK  = 2'd1;
   localparam logic [1:0] KIND_NAK  = 2'd2;

   // action codes
   localparam logic [2:0] ACT_SEND_DATA = 3'd0;
   localparam logic [2:0] ACT_SEND_ACK  = 3'd1;
   localparam logic [2:0] ACT_SEND_NAK  = 3'd2;
   localparam logic [2:0] ACT_DELIVER   = 3'd3;
   localparam logic [2:0] ACT_ACK_TIMER = 3'd4;
   localparam logic [2:0] ACT_STOP_TMR  = 3'd5;
   localparam logic [2:0] ACT_STATUS    = 3'd6;

   typedef struct packed {
      logic [2:0]       func;
      logic             frame_good;
      logic [1:0]       rx_kind;
      logic [SEQ_W-1:0] rx_seq;
      logic [SEQ_W-1:0] rx_ack;
   } req_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [SEQ_W-1:0]  tx_seq;
      logic [SEQ_W-1:0]  tx_ack;
      logic [SLOT_W-1:0] slot;
      logic              net_enable;
      logic              last;
   } rsp_type;

   // timer queue port bundle
   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_idx;
      logic [SEQ_W-1:0]  wr_data;
      logic [SLOT_W-1:0] rd_idx;
   } tq_ctrl_type;

   // a <= b < c, circularly
   function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                      input logic [SEQ_W-1:0] b,
                                      input logic [SEQ_W-1:0] c);
      in_window = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) ||
                  ((b < c) && (c < a));
   endfunction

endpackage
`default_nettype wire

[src/selective_repeat_link_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_link_controller: control side of a selective-repeat link
// Sequencer over window state, a shared circular window compare and a queue.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with an event on req_data while busy is low; the event is
//   taken at that edge and busy rises in the next cycle. Result beats leave
//   on rsp_data, one per cycle at most, each marked by rsp_valid for exactly
//   one cycle. The receiver cannot stall. The last beat of every event is a
//   status beat with last set, carrying net_enable.
//   Beats are registered: the first can be formed in the dispatch state,
//   and a status-only event forms its one beat in the status state.
//   Steps: dispatch and status come in every event, and the sequencer
//   returns to idle before the next one. A good data frame adds the
//   receive check; every good frame adds the post step and the final
//   acknowledge check, a NAK frame also the NAK check. Delivery takes a
//   step per delivered slot plus one, and each acknowledged frame a pass
//   of the acknowledge loop; every timer removal and every retransmit
//   adds a queue scan over the queue entries plus one closing step.
//   busy falls in the cycle after the status beat is formed, so a new event
//   may be taken while that beat is still on the result port.
//   Reset clears the window edges, counts, arrival bits and phy flag, sets
//   nak_ok and sets recv_high_ff to the window size. Queue entries are undefined until written.
// ----------------------------------------------------------------------------
module selective_repeat_link_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire srlc_pkg::req_type req_data,
   output logic                   rsp_valid,
   output srlc_pkg::rsp_type      rsp_data
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISPATCH  = 4'd1;
   localparam logic [3:0] S_RX_CHECK  = 4'd2;
   localparam logic [3:0] S_DELIVER   = 4'd3;
   localparam logic [3:0] S_POST      = 4'd4;
   localparam logic [3:0] S_NAK_CHECK = 4'd5;
   localparam logic [3:0] S_ACK_LOOP  = 4'd6;
   localparam logic [3:0] S_REMOVE    = 4'd7;
   localparam logic [3:0] S_SEND      = 4'd8;
   localparam logic [3:0] S_STATUS    = 4'd9;

   localparam logic [srlc_pkg::CNT_W-1:0] WIN_CNT = srlc_pkg::CNT_W'(srlc_pkg::WINDOW);

   logic [3:0] state_ff, state_in;
   logic [3:0] after_rm_ff, after_rm_in;
   logic [3:0] after_send_ff, after_send_in;
   srlc_pkg::req_type req_ff, req_in;

   logic [srlc_pkg::SEQ_W-1:0] send_low_ff, send_low_in;
   logic [srlc_pkg::SEQ_W-1:0] send_next_ff, send_next_in;
   logic [srlc_pkg::SEQ_W-1:0] recv_low_ff, recv_low_in;
   logic [srlc_pkg::SEQ_W-1:0] recv_high_ff, recv_high_in;
   logic [srlc_pkg::CNT_W-1:0] outst_ff, outst_in;
   logic [srlc_pkg::CNT_W-1:0] qlen_ff, qlen_in;
   logic [srlc_pkg::WINDOW-1:0] arrived_ff, arrived_in;
   logic nak_ok_ff, nak_ok_in;
   logic phy_ff, phy_in;
   logic delivered_ff, delivered_in;
   logic found_ff, found_in;
   logic [srlc_pkg::CNT_W-1:0] k_ff, k_in;
   logic [srlc_pkg::SEQ_W-1:0] seq_ff, seq_in;

   logic rsp_valid_ff, rsp_valid_in;
   srlc_pkg::rsp_type rsp_ff, rsp_in;

   srlc_pkg::tq_ctrl_type tq_ctrl;
   logic [srlc_pkg::SEQ_W-1:0] tq_rd;

   logic [srlc_pkg::SEQ_W-1:0] win_a, win_b, win_c;
   logic win_hit;
   logic [srlc_pkg::SEQ_W-1:0] piggy;
   logic [srlc_pkg::SEQ_W-1:0] nak_next;

   srlc_tq u_tq (
      .clock   (clock),
      .ctrl    (tq_ctrl),
      .rd_data (tq_rd)
   );

   assign piggy    = recv_low_ff - srlc_pkg::SEQ_W'(1);
   assign nak_next = req_ff.rx_ack + srlc_pkg::SEQ_W'(1);

   // shared circular window compare
   always_comb begin
      win_a = send_low_ff;
      win_b = req_ff.rx_ack;
      win_c = send_next_ff;
      if (state_ff == S_RX_CHECK) begin
         win_a = recv_low_ff;
         win_b = req_ff.rx_seq;
         win_c = recv_high_ff;
      end else if (state_ff == S_NAK_CHECK) begin
         win_b = nak_next;
      end
   end
   assign win_hit = srlc_pkg::in_window(win_a, win_b, win_c);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      after_rm_in   = after_rm_ff;
      after_send_in = after_send_ff;
      req_in        = req_ff;
      send_low_in   = send_low_ff;
      send_next_in  = send_next_ff;
      recv_low_in   = recv_low_ff;
      recv_high_in  = recv_high_ff;
      outst_in      = outst_ff;
      qlen_in       = qlen_ff;
      arrived_in    = arrived_ff;
      nak_ok_in     = nak_ok_ff;
      phy_in        = phy_ff;
      delivered_in  = delivered_ff;
      found_in      = found_ff;
      k_in          = k_ff;
      seq_in        = seq_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      tq_ctrl       = '0;
      if (state_ff == S_REMOVE) begin
         tq_ctrl.rd_idx = k_ff[srlc_pkg::SLOT_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_STATUS;
            unique case (req_ff.func)
               srlc_pkg::FUNC_NET_READY: begin
                  if (outst_ff < WIN_CNT) begin
                     outst_in      = outst_ff + srlc_pkg::CNT_W'(1);
                     seq_in        = send_next_ff;
                     send_next_in  = send_next_ff + srlc_pkg::SEQ_W'(1);
                     after_send_in = S_STATUS;
                     state_in      = S_SEND;
                  end
               end
               srlc_pkg::FUNC_PHY_READY: begin
                  phy_in = 1'b1;
               end
               srlc_pkg::FUNC_FRAME_RX: begin
                  if (!req_ff.frame_good) begin
                     if (nak_ok_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.action = srlc_pkg::ACT_SEND_NAK;
                        rsp_in.tx_ack = piggy;
                        phy_in        = 1'b0;
                        nak_ok_in     = 1'b0;
                     end
                  end else if (req_ff.rx_kind == srlc_pkg::KIND_DATA) begin
                     rsp_valid_in = 1'b1;
                     if (req_ff.rx_seq != recv_low_ff && nak_ok_ff) begin
                        rsp_in.action = srlc_pkg::ACT_SEND_NAK;
                        rsp_in.tx_ack = piggy;
                        phy_in        = 1'b0;
                        nak_ok_in     = 1'b0;
                     end else begin
                        rsp_in.action = srlc_pkg::ACT_ACK_TIMER;
                     end
                     state_in = S_RX_CHECK;
                  end else begin
                     state_in = S_POST;
                  end
               end
               srlc_pkg::FUNC_DATA_TMO: begin
                  // rotate the oldest entry to the tail and resend it
                  if (qlen_ff != '0) begin
                     seq_in        = tq_rd;
                     k_in          = '0;
                     found_in      = 1'b0;
                     after_rm_in   = S_SEND;
                     after_send_in = S_STATUS;
                     state_in      = S_REMOVE;
                  end
               end
               srlc_pkg::FUNC_ACK_TMO: begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.action = srlc_pkg::ACT_SEND_ACK;
                  rsp_in.tx_ack = piggy;
                  phy_in        = 1'b0;
               end
               default: begin
                  state_in = S_STATUS;
               end
            endcase
         end
         S_RX_CHECK: begin
            state_in = S_POST;
            if (win_hit && !arrived_ff[req_ff.rx_seq[srlc_pkg::SLOT_W-1:0]]) begin
               arrived_in[req_ff.rx_seq[srlc_pkg::SLOT_W-1:0]] = 1'b1;
               delivered_in = 1'b0;
               state_in     = S_DELIVER;
            end
         end
         S_DELIVER: begin
            // one in-order slot per cycle
            if (arrived_ff[recv_low_ff[srlc_pkg::SLOT_W-1:0]]) begin
               rsp_valid_in  = 1'b1;
               rsp_in.action = srlc_pkg::ACT_DELIVER;
               rsp_in.slot   = recv_low_ff[srlc_pkg::SLOT_W-1:0];
               nak_ok_in     = 1'b1;
               arrived_in[recv_low_ff[srlc_pkg::SLOT_W-1:0]] = 1'b0;
               recv_low_in   = recv_low_ff + srlc_pkg::SEQ_W'(1);
               recv_high_in  = recv_high_ff + srlc_pkg::SEQ_W'(1);
               delivered_in  = 1'b1;
            end else begin
               if (delivered_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.action = srlc_pkg::ACT_ACK_TIMER;
               end
               state_in = S_POST;
            end
         end
         S_POST: begin
            state_in = (req_ff.rx_kind == srlc_pkg::KIND_NAK) ? S_NAK_CHECK : S_ACK_LOOP;
         end
         S_NAK_CHECK: begin
            state_in = S_ACK_LOOP;
            if (win_hit) begin
               seq_in        = nak_next;
               k_in          = '0;
               found_in      = 1'b0;
               after_rm_in   = S_SEND;
               after_send_in = S_ACK_LOOP;
               state_in      = S_REMOVE;
            end
         end
         S_ACK_LOOP: begin
            // retire one acknowledged frame per pass
            state_in = S_STATUS;
            if (outst_ff != '0 && win_hit) begin
               outst_in      = outst_ff - srlc_pkg::CNT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_in.action = srlc_pkg::ACT_STOP_TMR;
               rsp_in.slot   = send_low_ff[srlc_pkg::SLOT_W-1:0];
               seq_in        = send_low_ff;
               send_low_in   = send_low_ff + srlc_pkg::SEQ_W'(1);
               k_in          = '0;
               found_in      = 1'b0;
               after_rm_in   = S_ACK_LOOP;
               state_in      = S_REMOVE;
            end
         end
         S_REMOVE: begin
            // scan; once matched, each later entry moves down one place
            if (k_ff < qlen_ff) begin
               if (found_ff) begin
                  tq_ctrl.wr_en   = 1'b1;
                  tq_ctrl.wr_idx  = k_ff[srlc_pkg::SLOT_W-1:0] - srlc_pkg::SLOT_W'(1);
                  tq_ctrl.wr_data = tq_rd;
               end else if (tq_rd == seq_ff) begin
                  found_in = 1'b1;
               end
               k_in = k_ff + srlc_pkg::CNT_W'(1);
            end else begin
               if (found_ff) begin
                  qlen_in = qlen_ff - srlc_pkg::CNT_W'(1);
               end
               state_in = after_rm_ff;
            end
         end
         S_SEND: begin
            rsp_valid_in  = 1'b1;
            rsp_in.action = srlc_pkg::ACT_SEND_DATA;
            rsp_in.tx_seq = seq_ff;
            rsp_in.tx_ack = piggy;
            rsp_in.slot   = seq_ff[srlc_pkg::SLOT_W-1:0];
            phy_in        = 1'b0;
            if (qlen_ff < WIN_CNT) begin
               tq_ctrl.wr_en   = 1'b1;
               tq_ctrl.wr_idx  = qlen_ff[srlc_pkg::SLOT_W-1:0];
               tq_ctrl.wr_data = seq_ff;
               qlen_in         = qlen_ff + srlc_pkg::CNT_W'(1);
            end
            state_in = after_send_ff;
         end
         S_STATUS: begin
            rsp_valid_in      = 1'b1;
            rsp_in.action     = srlc_pkg::ACT_STATUS;
            rsp_in.net_enable = (outst_ff < WIN_CNT) && phy_ff;
            rsp_in.last       = 1'b1;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         send_low_ff  <= '0;
         send_next_ff <= '0;
         recv_low_ff  <= '0;
         recv_high_ff <= srlc_pkg::SEQ_W'(srlc_pkg::WINDOW);
         outst_ff     <= '0;
         qlen_ff      <= '0;
         arrived_ff   <= '0;
         nak_ok_ff    <= 1'b1;
         phy_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         send_low_ff  <= send_low_in;
         send_next_ff <= send_next_in;
         recv_low_ff  <= recv_low_in;
         recv_high_ff <= recv_high_in;
         outst_ff     <= outst_in;
         qlen_ff      <= qlen_in;
         arrived_ff   <= arrived_in;
         nak_ok_ff    <= nak_ok_in;
         phy_ff       <= phy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      after_rm_ff   <= after_rm_in;
      after_send_ff <= after_send_in;
      req_ff        <= req_in;
      delivered_ff  <= delivered_in;
      found_ff      <= found_in;
      k_ff          <= k_in;
      seq_ff        <= seq_in;
      rsp_ff        <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

[src/srlc_tq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlc_tq: timer queue register file
// Eight sequence numbers in order of their data timers; one write, one read.
// ----------------------------------------------------------------------------
module srlc_tq (
   input  wire logic                      clock,
   input  wire srlc_pkg::tq_ctrl_type     ctrl,
   output logic [srlc_pkg::SEQ_W-1:0]     rd_data
);

   logic [srlc_pkg::SEQ_W-1:0] entry_ff [srlc_pkg::WINDOW];

   // write port
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         entry_ff[ctrl.wr_idx] <= ctrl.wr_data;
      end
   end

   // read port
   assign rd_data = entry_ff[ctrl.rd_idx];

endmodule
`default_nettype wire
